>>> hdl/trd_pkg.sv
// Shared types, telnet codes and sizing constants for the telnet receive decoder.
package trd_pkg;

  // Longest terminal-type name carried in a reply.
  localparam int TERM_NAME_CHARS = 8;
  localparam int NAME_IDX_W = (TERM_NAME_CHARS > 1) ? $clog2(TERM_NAME_CHARS) : 1;

  // Depth of the job queue between the parser and the result sequencer.
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

  // Telnet command and option codes.
  localparam logic [7:0] C_IAC  = 8'd255;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_BRK  = 8'd243;
  localparam logic [7:0] C_SE   = 8'd240;
  localparam logic [7:0] O_BINARY = 8'd0;
  localparam logic [7:0] O_ECHO   = 8'd1;
  localparam logic [7:0] O_SGA    = 8'd3;
  localparam logic [7:0] O_TERM   = 8'd24;
  localparam logic [7:0] SUB_IS   = 8'd0;
  localparam logic [7:0] SUB_SEND = 8'd1;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;

  // Terminal modes.
  localparam logic [1:0] MODE_REVERSE = 2'd0;
  localparam logic [1:0] MODE_ASCII   = 2'd1;

  typedef enum logic [2:0] {
    CFG_TERMINAL_MODE   = 3'd0,
    CFG_CRLF_TO_CR      = 3'd1,
    CFG_CRLF_TO_LF      = 3'd2,
    CFG_LF_TO_CR        = 3'd3,
    CFG_LF_TO_CRLF      = 3'd4,
    CFG_REFUSAL_ENABLE  = 3'd5,
    CFG_TERM_TYPE_TEXT  = 3'd6,
    CFG_TERM_TYPE_LEN   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DST_PORT = 2'd0,
    DST_NET  = 2'd1,
    DST_BRK  = 2'd2
  } dest_e;

  typedef enum logic [9:0] {
    PH_DATA = 10'b00_0000_0001,
    PH_CMD  = 10'b00_0000_0010,
    PH_WILL = 10'b00_0000_0100,
    PH_DO   = 10'b00_0000_1000,
    PH_DONT = 10'b00_0001_0000,
    PH_WONT = 10'b00_0010_0000,
    PH_SB0  = 10'b00_0100_0000,
    PH_SB1  = 10'b00_1000_0000,
    PH_SB2  = 10'b01_0000_0000,
    PH_SB3  = 10'b10_0000_0000
  } phase_e;

  // Main part of a result run.
  typedef enum logic [2:0] {
    MK_NONE  = 3'd0,
    MK_PORT  = 3'd1,
    MK_BRK   = 3'd2,
    MK_REPLY = 3'd3,
    MK_TERM  = 3'd4
  } main_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       short_chunk_end;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] destination;
    logic       tx_binary_now;
    logic       last_of_run;
  } res_item_t;

  typedef struct packed {
    logic [1:0]  terminal_mode;
    logic        crlf_to_cr;
    logic        crlf_to_lf;
    logic        lf_to_cr;
    logic        lf_to_crlf;
    logic        refusal_handling_enable;
    logic [63:0] term_type_text;
    logic [3:0]  term_type_length;
  } cfg_t;

  // One byte's worth of results: CR/LF prefix, main part, trailing CR.
  typedef struct packed {
    logic [1:0] pre_cnt;
    main_e      kind;
    logic [7:0] cmd;
    logic [7:0] ch;
    logic       suf_cr;
    logic       tx_binary;
  } job_t;

endpackage

>>> hdl/trd_front.sv
// Telnet parser front end: phase tracking, negotiation state and job building.
module trd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  trd_pkg::rx_item_t item_i,
  input  trd_pkg::cfg_t   cfg_i,
  input  logic            mode_load_i,
  input  logic [1:0]      mode_val_i,
  output trd_pkg::job_t   job_o,
  output logic            job_nonempty_o
);
  import trd_pkg::*;

  phase_e     phase_q, phase_d;
  logic       cr_q, cr_d;
  logic       rxb_q, rxb_d;
  logic       txb_q, txb_d;
  logic       offered_q, offered_d;
  logic       requested_q, requested_d;
  logic       asked_q, asked_d;
  logic [7:0] ch;
  logic       done;
  logic       cr_mid;
  logic       hold;

  always_comb begin
    ch          = item_i.rx_byte;
    phase_d     = phase_q;
    rxb_d       = rxb_q;
    txb_d       = txb_q;
    offered_d   = offered_q;
    requested_d = requested_q;
    asked_d     = asked_q;
    done        = 1'b0;
    hold        = 1'b0;
    cr_mid      = cr_q;
    job_o.pre_cnt   = 2'd0;
    job_o.kind      = MK_NONE;
    job_o.cmd       = C_IAC;
    job_o.ch        = ch;
    job_o.suf_cr    = 1'b0;

    // Resolve a held CR, or translate a bare LF.
    if (cr_q) begin
      cr_mid = 1'b0;
      if (ch == CH_NUL && !rxb_q) begin
        done = 1'b1;
      end else if (ch == CH_LF && cfg_i.crlf_to_cr) begin
        done = 1'b1;
      end else if (ch != CH_LF && cfg_i.crlf_to_lf) begin
        job_o.pre_cnt = 2'd1;
      end
    end else if (ch == CH_LF && phase_q == PH_DATA) begin
      if (cfg_i.lf_to_cr) begin
        job_o.pre_cnt = 2'd1;
        done = 1'b1;
      end else if (cfg_i.lf_to_crlf) begin
        job_o.pre_cnt = 2'd2;
        done = 1'b1;
      end
    end

    if (!done) begin
      unique case (phase_q)
        PH_DATA: begin
          if (ch == C_IAC) begin
            phase_d = PH_CMD;
          end else begin
            if (ch == CH_CR && (!rxb_q || cfg_i.crlf_to_cr || cfg_i.crlf_to_lf)) begin
              cr_mid = 1'b1;
              hold   = cfg_i.crlf_to_lf;
            end
            if (!hold) job_o.kind = MK_PORT;
          end
        end
        PH_CMD: begin
          phase_d = PH_DATA;
          if (ch == C_IAC) job_o.kind = MK_PORT;
          else if (ch == C_SB) phase_d = PH_SB0;
          else if (ch == C_WILL) phase_d = PH_WILL;
          else if (ch == C_DO) phase_d = PH_DO;
          else if (ch == C_DONT) phase_d = PH_DONT;
          else if (ch == C_WONT) phase_d = PH_WONT;
          else if (ch == C_BRK) job_o.kind = MK_BRK;
        end
        PH_DONT: begin
          phase_d = PH_DATA;
          if (cfg_i.refusal_handling_enable && ch == O_BINARY) begin
            txb_d = 1'b0;
            if (offered_q) begin
              offered_d  = 1'b0;
              job_o.kind = MK_REPLY;
              job_o.cmd  = C_WONT;
            end
          end
        end
        PH_WONT: begin
          phase_d = PH_DATA;
          if (cfg_i.refusal_handling_enable && ch == O_BINARY) begin
            rxb_d = 1'b0;
            if (requested_q) begin
              requested_d = 1'b0;
              job_o.kind  = MK_REPLY;
              job_o.cmd   = C_DONT;
            end
          end
        end
        PH_DO: begin
          phase_d = PH_DATA;
          if (ch == O_BINARY) begin
            txb_d = 1'b1;
            if (!offered_q) begin
              job_o.kind = MK_REPLY;
              job_o.cmd  = C_WILL;
            end
          end else if (ch == O_ECHO) begin
            if (cfg_i.terminal_mode != MODE_REVERSE) begin
              job_o.kind = MK_REPLY;
              job_o.cmd  = C_WONT;
            end
          end else if (ch != O_SGA && ch != O_TERM) begin
            job_o.kind = MK_REPLY;
            job_o.cmd  = C_WONT;
          end
        end
        PH_WILL: begin
          phase_d = PH_DATA;
          if (ch == O_BINARY) begin
            rxb_d = 1'b1;
            if (!requested_q) begin
              job_o.kind = MK_REPLY;
              job_o.cmd  = C_DO;
            end
          end else if (ch == O_ECHO) begin
            job_o.kind = MK_REPLY;
            job_o.cmd  = C_DO;
          end else if (ch != O_SGA && ch != O_TERM) begin
            job_o.kind = MK_REPLY;
            job_o.cmd  = C_DONT;
          end
        end
        PH_SB0: phase_d = (ch == O_TERM) ? PH_SB1 : PH_SB2;
        PH_SB1: begin
          if (ch == SUB_SEND) asked_d = 1'b1;
          phase_d = PH_SB2;
        end
        PH_SB2: begin
          if (ch == C_IAC) phase_d = PH_SB3;
        end
        PH_SB3: begin
          if (ch == C_SE) begin
            if (asked_q) job_o.kind = MK_TERM;
            asked_d = 1'b0;
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_SB2;
          end
        end
        default: phase_d = PH_DATA;
      endcase
    end

    // A chunk end settles a CR that is still pending.
    if (cr_mid && item_i.short_chunk_end) begin
      job_o.suf_cr = cfg_i.crlf_to_lf;
      cr_mid       = 1'b0;
    end
    cr_d            = cr_mid;
    job_o.tx_binary = txb_d;
    job_nonempty_o  = (job_o.pre_cnt != 2'd0) || (job_o.kind != MK_NONE) || job_o.suf_cr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      cr_q        <= 1'b0;
      rxb_q       <= 1'b0;
      txb_q       <= 1'b0;
      offered_q   <= 1'b1;
      requested_q <= 1'b1;
      asked_q     <= 1'b0;
    end else if (mode_load_i) begin
      offered_q   <= (mode_val_i != MODE_ASCII);
      requested_q <= (mode_val_i != MODE_ASCII);
    end else if (accept_i) begin
      phase_q     <= phase_d;
      cr_q        <= cr_d;
      rxb_q       <= rxb_d;
      txb_q       <= txb_d;
      offered_q   <= offered_d;
      requested_q <= requested_d;
      asked_q     <= asked_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A held CR is only ever set from the data phase and resolved by the next byte.
  a_cr_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_q |-> phase_q == PH_DATA)
    else $error("CR pending outside data phase");
`endif

endmodule

>>> hdl/trd_job_fifo.sv
// Short job queue between the parser and the result sequencer.
module trd_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  trd_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output trd_pkg::job_t job_o
);
  import trd_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_PTR_W:0]   cnt_q;

  function automatic logic [JOB_PTR_W-1:0] ptr_next(input logic [JOB_PTR_W-1:0] p);
    return (p == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == (JOB_PTR_W + 1)'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      cnt_q <= cnt_q + (JOB_PTR_W + 1)'(push_i) - (JOB_PTR_W + 1)'(pop_i);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue read while empty");
`endif

endmodule

>>> hdl/trd_back.sv
// Result sequencer: expands a job into result transfers through an output register.
module trd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  trd_pkg::job_t     job_i,
  input  logic [63:0]       term_text_i,
  input  logic [3:0]        term_len_i,
  output logic              job_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output trd_pkg::res_item_t item_o
);
  import trd_pkg::*;

  localparam logic [3:0] REPLY_LEN   = 4'd3;
  localparam logic [3:0] TERM_FRAME  = 4'd6;
  localparam logic [3:0] TERM_HEAD   = 4'd4;

  logic [3:0]      idx_q;
  logic            out_valid_q;
  res_item_t       out_q;
  res_item_t       item;
  logic [3:0]      name_len;
  logic [3:0]      main_len;
  logic [3:0]      run_len;
  logic [3:0]      j;
  logic [3:0]      name_sel;
  logic [7:0]      name_bytes [TERM_NAME_CHARS];
  logic            last;
  logic            emit;

  always_comb begin
    for (int k = 0; k < TERM_NAME_CHARS; k++) begin
      name_bytes[k] = term_text_i[8*k +: 8];
    end
  end

  always_comb begin
    name_len = (term_len_i > 4'(TERM_NAME_CHARS)) ? 4'(TERM_NAME_CHARS) : term_len_i;
    unique case (job_i.kind) inside
      MK_PORT, MK_BRK: main_len = 4'd1;
      MK_REPLY:        main_len = REPLY_LEN;
      MK_TERM:         main_len = TERM_FRAME + name_len;
      default:         main_len = 4'd0;
    endcase
    run_len  = {2'b00, job_i.pre_cnt} + main_len + {3'b000, job_i.suf_cr};
    j        = idx_q - {2'b00, job_i.pre_cnt};
    name_sel = j - TERM_HEAD;

    item.destination = DST_PORT;
    item.out_byte    = CH_CR;
    if (idx_q < {2'b00, job_i.pre_cnt}) begin
      item.out_byte = (idx_q == 4'd0) ? CH_CR : CH_LF;
    end else if (j < main_len) begin
      case (job_i.kind)
        MK_BRK: begin
          item.out_byte    = 8'd0;
          item.destination = DST_BRK;
        end
        MK_REPLY: begin
          item.destination = DST_NET;
          if (j == 4'd0)      item.out_byte = C_IAC;
          else if (j == 4'd1) item.out_byte = job_i.cmd;
          else                item.out_byte = job_i.ch;
        end
        MK_TERM: begin
          item.destination = DST_NET;
          if (j == 4'd0)                      item.out_byte = C_IAC;
          else if (j == 4'd1)                 item.out_byte = C_SB;
          else if (j == 4'd2)                 item.out_byte = O_TERM;
          else if (j == 4'd3)                 item.out_byte = SUB_IS;
          else if (name_sel < name_len)       item.out_byte = name_bytes[name_sel[NAME_IDX_W-1:0]];
          else if (name_sel == name_len)      item.out_byte = C_IAC;
          else                                item.out_byte = C_SE;
        end
        default: item.out_byte = job_i.ch;
      endcase
    end
    last               = (idx_q == run_len - 4'd1);
    item.tx_binary_now = job_i.tx_binary;
    item.last_of_run   = last;
  end

  // Load the output register from a queued job whenever it is free or being drained.
  assign emit      = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = emit && last;
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        idx_q       <= last ? 4'd0 : idx_q + 4'd1;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < run_len)
    else $error("sequencer index past end of run");
`endif

endmodule

>>> hdl/telnet_receive_decoder.sv
// Path: an accepted byte's job is written into the job queue, and the result
// sequencer loads its first result into the output register on the ports.
// Throughput: one byte per cycle while each byte gives at most one result and pop
// keeps up; a byte with more results holds the sequencer for its whole run, and
// a four-job queue absorbs such runs (bytes with no result are not queued but
// still need room in it). Reset is asynchronous and clears control state only;
// binary offers come up set, as for terminal mode 0. No clearing pass is needed.
module telnet_receive_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Received byte side
  input  logic                push,
  output logic                full,
  input  trd_pkg::rx_item_t   in_item_i,
  // Result side
  output logic                empty,
  input  logic                pop,
  output trd_pkg::res_item_t  out_item_o,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [63:0]         cfg_wdata_i
);
  import trd_pkg::*;

  cfg_t  cfg_q;
  job_t  front_job;
  job_t  head_job;
  logic  front_nonempty;
  logic  in_xfer;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  logic  q_full;
  logic  mode_load;

  // Transfer a byte whenever the job queue has room.
  assign full    = q_full;
  assign in_xfer = push && !q_full;
  // Drop bytes that yield no result; they only advance parser state.
  assign q_push  = in_xfer && front_nonempty;

  // Writing the terminal mode restarts the binary negotiation flags.
  assign mode_load = cfg_we_i && (cfg_addr_i == CFG_TERMINAL_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TERMINAL_MODE:  cfg_q.terminal_mode           <= cfg_wdata_i[1:0];
        CFG_CRLF_TO_CR:     cfg_q.crlf_to_cr              <= cfg_wdata_i[0];
        CFG_CRLF_TO_LF:     cfg_q.crlf_to_lf              <= cfg_wdata_i[0];
        CFG_LF_TO_CR:       cfg_q.lf_to_cr                <= cfg_wdata_i[0];
        CFG_LF_TO_CRLF:     cfg_q.lf_to_crlf              <= cfg_wdata_i[0];
        CFG_REFUSAL_ENABLE: cfg_q.refusal_handling_enable <= cfg_wdata_i[0];
        CFG_TERM_TYPE_TEXT: cfg_q.term_type_text          <= cfg_wdata_i;
        CFG_TERM_TYPE_LEN:  cfg_q.term_type_length        <= cfg_wdata_i[3:0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  // Parse and classify each received byte.
  trd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .item_i         (in_item_i),
    .cfg_i          (cfg_q),
    .mode_load_i    (mode_load),
    .mode_val_i     (cfg_wdata_i[1:0]),
    .job_o          (front_job),
    .job_nonempty_o (front_nonempty)
  );

  // Decouple parsing from result delivery.
  trd_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Expand each job into result transfers, one per cycle while pop keeps up.
  trd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .term_text_i (cfg_q.term_type_text),
    .term_len_i  (cfg_q.term_type_length),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // Every queued job must be producing results, so the queue drains on its own.
  a_queue_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && empty) |=> !empty)
    else $error("pending job did not reach the output register");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the telnet receive decoder: directed and random byte streams.
module tb_top;
  import trd_pkg::*;

  // Terminal mode 2 has no name in the package.
  localparam logic [1:0] MODE_BINARY    = 2'd2;
  // Longest run of results one received byte can cause.
  localparam int         MAX_RUN        = 14;
  // Idle time after a drain: enough for silent bytes to retire.
  localparam int         SETTLE_CYCLES  = 12;
  localparam int         WATCHDOG_LIMIT = 4000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  rx_item_t   rx_item     = '0;
  logic       empty;
  logic       pop         = 1'b0;
  res_item_t  out_item;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_addr_i  = '0;
  logic [63:0] cfg_wdata_i = '0;

  telnet_receive_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (rx_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Idle rates of the two sides, in percent of cycles.
  int send_gap_pct = 13;
  int pop_stall_pct = 53;

  int fail_count = 0;
  int quiet_cycles = 0;

  // Decoder shadow: configuration and parser state.
  cfg_t   shadow;
  phase_e dec_phase;
  logic   cr_held;
  logic   rx_bin;
  logic   tx_bin;
  logic   offered_bin;
  logic   requested_bin;
  logic   tt_asked;

  // Results of the byte being decoded, then the stream still owed by the block.
  res_item_t byte_results[$];
  res_item_t owed_results[$];
  res_item_t want;

  // ---------------------------------------------------------------------------
  // Decoder shadow
  // ---------------------------------------------------------------------------

  function automatic void emit(input logic [7:0] b, input dest_e d);
    res_item_t r;
    if (byte_results.size() >= MAX_RUN) return;
    r.out_byte      = b;
    r.destination   = d;
    r.tx_binary_now = 1'b0;
    r.last_of_run   = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void emit_reply(input logic [7:0] cmd, input logic [7:0] opt);
    emit(C_IAC, DST_NET);
    emit(cmd, DST_NET);
    emit(opt, DST_NET);
  endfunction

  // One byte through the telnet parser proper.
  function automatic void parse_byte(input logic [7:0] ch);
    logic hold;
    int   len;
    case (dec_phase)
      PH_DATA: begin
        if (ch == C_IAC) begin
          dec_phase = PH_CMD;
        end else begin
          hold = 1'b0;
          if (ch == CH_CR && (!rx_bin || shadow.crlf_to_cr || shadow.crlf_to_lf)) begin
            cr_held = 1'b1;
            hold    = shadow.crlf_to_lf;
          end
          if (!hold) emit(ch, DST_PORT);
        end
      end
      PH_CMD: begin
        dec_phase = PH_DATA;
        if (ch == C_IAC) emit(ch, DST_PORT);
        else if (ch == C_SB) dec_phase = PH_SB0;
        else if (ch == C_WILL) dec_phase = PH_WILL;
        else if (ch == C_DO) dec_phase = PH_DO;
        else if (ch == C_DONT) dec_phase = PH_DONT;
        else if (ch == C_WONT) dec_phase = PH_WONT;
        else if (ch == C_BRK) emit(CH_NUL, DST_BRK);
      end
      PH_DONT: begin
        dec_phase = PH_DATA;
        if (shadow.refusal_handling_enable && ch == O_BINARY) begin
          tx_bin = 1'b0;
          if (offered_bin) begin
            offered_bin = 1'b0;
            emit_reply(C_WONT, ch);
          end
        end
      end
      PH_WONT: begin
        dec_phase = PH_DATA;
        if (shadow.refusal_handling_enable && ch == O_BINARY) begin
          rx_bin = 1'b0;
          if (requested_bin) begin
            requested_bin = 1'b0;
            emit_reply(C_DONT, ch);
          end
        end
      end
      PH_DO: begin
        dec_phase = PH_DATA;
        if (ch == O_BINARY) begin
          tx_bin = 1'b1;
          if (!offered_bin) emit_reply(C_WILL, ch);
        end else if (ch == O_ECHO) begin
          if (shadow.terminal_mode != MODE_REVERSE) emit_reply(C_WONT, ch);
        end else if (ch != O_SGA && ch != O_TERM) begin
          emit_reply(C_WONT, ch);
        end
      end
      PH_WILL: begin
        dec_phase = PH_DATA;
        if (ch == O_BINARY) begin
          rx_bin = 1'b1;
          if (!requested_bin) emit_reply(C_DO, ch);
        end else if (ch == O_ECHO) begin
          emit_reply(C_DO, ch);
        end else if (ch != O_SGA && ch != O_TERM) begin
          emit_reply(C_DONT, ch);
        end
      end
      PH_SB0: dec_phase = (ch == O_TERM) ? PH_SB1 : PH_SB2;
      PH_SB1: begin
        if (ch == SUB_SEND) tt_asked = 1'b1;
        dec_phase = PH_SB2;
      end
      PH_SB2: if (ch == C_IAC) dec_phase = PH_SB3;
      PH_SB3: begin
        if (ch == C_SE) begin
          if (tt_asked) begin
            emit(C_IAC, DST_NET);
            emit(C_SB, DST_NET);
            emit(O_TERM, DST_NET);
            emit(SUB_IS, DST_NET);
            len = int'(shadow.term_type_length);
            if (len > TERM_NAME_CHARS) len = TERM_NAME_CHARS;
            for (int k = 0; k < len; k++) emit(shadow.term_type_text[8*k +: 8], DST_NET);
            emit(C_IAC, DST_NET);
            emit(C_SE, DST_NET);
          end
          tt_asked  = 1'b0;
          dec_phase = PH_DATA;
        end else begin
          dec_phase = PH_SB2;
        end
      end
      default: dec_phase = PH_DATA;
    endcase
  endfunction

  // Work out every result one accepted byte causes and queue them as owed.
  function automatic void decode_byte(input rx_item_t item);
    logic [7:0] ch;
    logic       done;
    ch   = item.rx_byte;
    done = 1'b0;
    byte_results.delete();
    // Resolve a held CR first; otherwise apply the bare-LF translations.
    if (cr_held) begin
      cr_held = 1'b0;
      if (ch == CH_NUL && !rx_bin) done = 1'b1;
      else if (ch == CH_LF && shadow.crlf_to_cr) done = 1'b1;
      else if (ch != CH_LF && shadow.crlf_to_lf) emit(CH_CR, DST_PORT);
    end else if (ch == CH_LF && dec_phase == PH_DATA) begin
      if (shadow.lf_to_cr) begin
        emit(CH_CR, DST_PORT);
        done = 1'b1;
      end else if (shadow.lf_to_crlf) begin
        emit(CH_CR, DST_PORT);
        emit(CH_LF, DST_PORT);
        done = 1'b1;
      end
    end
    if (!done) parse_byte(ch);
    // A chunk that ends on a held CR resolves it right there.
    if (cr_held && item.short_chunk_end) begin
      if (shadow.crlf_to_lf) emit(CH_CR, DST_PORT);
      cr_held = 1'b0;
    end
    foreach (byte_results[k]) begin
      byte_results[k].tx_binary_now = tx_bin;
      byte_results[k].last_of_run   = (k == byte_results.size() - 1);
      owed_results.push_back(byte_results[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one byte, hold it until the transfer, then predict its results.
  task automatic send_byte(input logic [7:0] b, input logic chunk_end);
    rx_item_t item;
    item.rx_byte         = b;
    item.short_chunk_end = chunk_end;
    if ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    push    <= 1'b1;
    rx_item <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    decode_byte(item);
  endtask

  // Drop push and wait for every owed result; optionally let silent bytes retire.
  task automatic drain(input bit settle);
    push <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_TERMINAL_MODE: begin
        // A mode write restarts the binary offers, as at session start.
        shadow.terminal_mode = value[1:0];
        offered_bin          = (value[1:0] != MODE_ASCII);
        requested_bin        = (value[1:0] != MODE_ASCII);
      end
      CFG_CRLF_TO_CR:     shadow.crlf_to_cr              = value[0];
      CFG_CRLF_TO_LF:     shadow.crlf_to_lf              = value[0];
      CFG_LF_TO_CR:       shadow.lf_to_cr                = value[0];
      CFG_LF_TO_CRLF:     shadow.lf_to_crlf              = value[0];
      CFG_REFUSAL_ENABLE: shadow.refusal_handling_enable = value[0];
      CFG_TERM_TYPE_TEXT: shadow.term_type_text          = value;
      CFG_TERM_TYPE_LEN:  shadow.term_type_length        = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_t s);
    write_reg(CFG_TERMINAL_MODE, 64'(s.terminal_mode));
    write_reg(CFG_CRLF_TO_CR, 64'(s.crlf_to_cr));
    write_reg(CFG_CRLF_TO_LF, 64'(s.crlf_to_lf));
    write_reg(CFG_LF_TO_CR, 64'(s.lf_to_cr));
    write_reg(CFG_LF_TO_CRLF, 64'(s.lf_to_crlf));
    write_reg(CFG_REFUSAL_ENABLE, 64'(s.refusal_handling_enable));
    write_reg(CFG_TERM_TYPE_TEXT, s.term_type_text);
    write_reg(CFG_TERM_TYPE_LEN, 64'(s.term_type_length));
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t random_setting();
    cfg_t s;
    s.terminal_mode           = 2'($urandom_range(2));
    s.crlf_to_cr              = 1'($urandom_range(1));
    s.crlf_to_lf              = 1'($urandom_range(1));
    s.lf_to_cr                = 1'($urandom_range(1));
    s.lf_to_crlf              = 1'($urandom_range(1));
    s.refusal_handling_enable = 1'($urandom_range(1));
    s.term_type_text          = {$urandom(), $urandom()};
    s.term_type_length        = 4'($urandom_range(TERM_NAME_CHARS));
    return s;
  endfunction

  // Plain data: extremes, IAC doubling, CR/LF handling, NUL after CR,
  // chunk end on a held CR, break and an unknown command.
  task automatic test_data_bytes();
    cfg_t s;
    s.terminal_mode           = MODE_BINARY;
    s.crlf_to_cr              = 1'b0;
    s.crlf_to_lf              = 1'b1;
    s.lf_to_cr                = 1'b0;
    s.lf_to_crlf              = 1'b1;
    s.refusal_handling_enable = 1'b1;
    s.term_type_text          = 64'h0000_0000_6973_6E61;
    s.term_type_length        = 4'd4;
    apply_setting(s);
    send_byte(8'h00, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(C_BRK, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // Option replies, an LF inside a negotiation and a terminal-type request.
  task automatic test_option_replies();
    send_byte(C_IAC, 1'b0);
    send_byte(C_DO, 1'b0);
    send_byte(O_BINARY, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(C_WILL, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(C_DONT, 1'b0);
    send_byte(O_BINARY, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(C_SB, 1'b0);
    send_byte(O_TERM, 1'b0);
    send_byte(SUB_SEND, 1'b0);
    send_byte(C_IAC, 1'b0);
    send_byte(C_SE, 1'b1);
  endtask

  // Mostly well-formed telnet traffic with random content, plus noise and
  // broken subnegotiations.
  task automatic test_random_traffic(input cfg_t s, input int n_bytes, input int gap_pct,
                                     input int stall_pct, input bit hold_off);
    logic [7:0] token[$];
    int         sent;
    bit         paused;
    drain(1'b1);
    apply_setting(s);
    send_gap_pct  = gap_pct;
    pop_stall_pct = stall_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_bytes) begin
      token.delete();
      case ($urandom_range(9))
        0, 1, 2: begin
          case ($urandom_range(4))
            0:       token.push_back(CH_CR);
            1:       token.push_back(CH_LF);
            2:       token.push_back(CH_NUL);
            default: token.push_back(8'($urandom_range(255)));
          endcase
        end
        3: token = '{C_IAC, C_IAC};
        4, 5: begin
          token.push_back(C_IAC);
          case ($urandom_range(3))
            0: token.push_back(C_WILL);
            1: token.push_back(C_DO);
            2: token.push_back(C_DONT);
            default: token.push_back(C_WONT);
          endcase
          case ($urandom_range(5))
            0, 1: token.push_back(O_BINARY);
            2:    token.push_back(O_ECHO);
            3:    token.push_back(O_SGA);
            4:    token.push_back(O_TERM);
            default: token.push_back(8'($urandom_range(255)));
          endcase
        end
        6: begin
          token = '{C_IAC, C_SB};
          token.push_back(($urandom_range(3) != 0) ? O_TERM : 8'($urandom_range(255)));
          token.push_back(($urandom_range(2) != 0) ? SUB_SEND : 8'($urandom_range(255)));
          repeat ($urandom_range(2)) token.push_back(8'($urandom_range(255)));
          token.push_back(C_IAC);
          // Now and then break the closing pair and leave the parser inside.
          token.push_back(($urandom_range(5) != 0) ? C_SE : 8'($urandom_range(255)));
        end
        7: token = '{C_IAC, C_BRK};
        8: token = '{C_IAC, 8'($urandom_range(255))};
        default: token.push_back(8'($urandom_range(255)));
      endcase
      foreach (token[i]) send_byte(token[i], $urandom_range(7) == 0);
      sent += token.size();
      // Hold off the sender once until the block has handed over everything.
      if (hold_off && !paused && sent >= n_bytes / 2) begin
        drain(1'b0);
        paused = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every transfer out is matched to the oldest owed result
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result: out_byte %0h destination %0d", out_item.out_byte,
               out_item.destination);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_item.out_byte);
          fail_count++;
        end
        if (out_item.destination !== want.destination) begin
          $error("destination: expected %0d, got %0d", want.destination,
                 out_item.destination);
          fail_count++;
        end
        if (out_item.tx_binary_now !== want.tx_binary_now) begin
          $error("tx_binary_now: expected %0b, got %0b", want.tx_binary_now,
                 out_item.tx_binary_now);
          fail_count++;
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 out_item.last_of_run);
          fail_count++;
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // End the run if neither side has made a transfer for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_t low_setting;
    cfg_t high_setting;
    cfg_t ascii_setting;
    // Reset state of the shadow: all registers zero, binary offered.
    shadow        = '0;
    dec_phase     = PH_DATA;
    cr_held       = 1'b0;
    rx_bin        = 1'b0;
    tx_bin        = 1'b0;
    offered_bin   = 1'b1;
    requested_bin = 1'b1;
    tt_asked      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_data_bytes();
    test_option_replies();

    low_setting                = '0;
    high_setting               = '1;
    high_setting.terminal_mode = MODE_BINARY;
    high_setting.term_type_length = 4'(TERM_NAME_CHARS);
    ascii_setting              = random_setting();
    ascii_setting.terminal_mode = MODE_ASCII;

    // Sender idles lightly, receiver heavily; then the other way round; then neither.
    test_random_traffic(low_setting, 60, 13, 53, 1'b0);
    test_random_traffic(high_setting, 60, 13, 53, 1'b1);
    test_random_traffic(ascii_setting, 60, 53, 13, 1'b0);
    test_random_traffic(random_setting(), 60, 53, 13, 1'b1);
    test_random_traffic(random_setting(), 60, 0, 0, 1'b0);
    test_random_traffic(random_setting(), 60, 0, 0, 1'b1);

    drain(1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
